/* hdl/tle_pkg.sv */
// Shared types, codes and sizes of the terminal line editor.
package tle_pkg;

    // Default line buffer size; the line holds two characters fewer.
    localparam int BUFFER_SIZE_DEF = 32;

    // Entries of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Key event codes.
    localparam logic [3:0] ACT_INSERT = 4'd0;
    localparam logic [3:0] ACT_BACKSP = 4'd1;
    localparam logic [3:0] ACT_DELETE = 4'd2;
    localparam logic [3:0] ACT_LEFT   = 4'd3;
    localparam logic [3:0] ACT_RIGHT  = 4'd4;
    localparam logic [3:0] ACT_HOME   = 4'd5;
    localparam logic [3:0] ACT_END    = 4'd6;
    localparam logic [3:0] ACT_KILL   = 4'd7;
    localparam logic [3:0] ACT_ACCEPT = 4'd8;
    localparam logic [3:0] ACT_CANCEL = 4'd9;

    // Echo token kinds.
    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_BELL   = 3'd1;
    localparam logic [2:0] KIND_LEFT   = 3'd2;
    localparam logic [2:0] KIND_RIGHT  = 3'd3;
    localparam logic [2:0] KIND_ERASE  = 3'd4;
    localparam logic [2:0] KIND_VALUE  = 3'd5;
    localparam logic [2:0] KIND_DONE   = 3'd6;
    localparam logic [2:0] KIND_CANCEL = 3'd7;

    localparam logic [6:0] CH_SPACE = 7'd32;

    // A classified key event as it travels through the queue.
    typedef struct packed {
        logic [3:0] op;
        logic       ch_ok;
        logic [6:0] ch;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* hdl/tle_front.sv */
// Input stage: takes key events, drops unknown codes, and feeds the queue.
module tle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [3:0]      i_action,
    input  logic [7:0]      i_char_code,
    input  tle_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output tle_pkg::t_cmd   o_cmd
);

    logic          r_valid;
    tle_pkg::t_cmd r_cmd;
    logic          w_accept;
    logic          w_known;

    assign o_stall  = r_valid && i_q_stat.full;
    assign o_push   = r_valid && !i_q_stat.full;
    assign o_cmd    = r_cmd;
    assign w_accept = i_valid && !o_stall;
    assign w_known  = i_action <= tle_pkg::ACT_CANCEL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            // Codes past cancel do nothing at all, so they never reach the queue.
            r_valid <= w_known;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.op    <= i_action;
            r_cmd.ch_ok <= !i_char_code[7];
            r_cmd.ch    <= i_char_code[6:0];
        end
    end

endmodule

/* hdl/tle_queue.sv */
// Short command queue that decouples the front from the back.
module tle_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tle_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output tle_pkg::t_cmd    o_cmd,
    output tle_pkg::t_q_stat o_stat
);

    localparam int QAW = (tle_pkg::QUEUE_DEPTH > 1) ? $clog2(tle_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(tle_pkg::QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] LAST_PTR = QAW'(tle_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] FULL_CNT = QCW'(tle_pkg::QUEUE_DEPTH);

    tle_pkg::t_cmd  r_q [tle_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_q[r_rp];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

/* hdl/tle_back.sv */
// Execution sequencer: holds the gap buffer and emits the echo tokens.
module tle_back #(
    parameter int BUFFER_SIZE = tle_pkg::BUFFER_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tle_pkg::t_cmd    i_q_cmd,
    input  tle_pkg::t_q_stat i_q_stat,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_out_char,
    output logic             o_last
);

    localparam int AW = $clog2(BUFFER_SIZE);
    localparam int LW = AW + 1;
    localparam logic [LW:0]   CAP_SUM = (LW + 1)'(BUFFER_SIZE - 2);
    localparam logic [LW-1:0] ONE     = LW'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HEAD  = 4'd1;
    localparam logic [3:0] S_ECHO  = 4'd2;
    localparam logic [3:0] S_SPACE = 4'd3;
    localparam logic [3:0] S_BACK  = 4'd4;
    localparam logic [3:0] S_MOVE  = 4'd5;
    localparam logic [3:0] S_KSP   = 4'd6;
    localparam logic [3:0] S_KLF   = 4'd7;
    localparam logic [3:0] S_VALL  = 4'd8;
    localparam logic [3:0] S_VALR  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [6:0] mem_l [BUFFER_SIZE];
    logic [6:0] mem_r [BUFFER_SIZE];
    logic [6:0] r_lq, r_rq;

    logic [3:0]    r_state, n_state;
    logic [LW-1:0] r_len_l, n_len_l;
    logic [LW-1:0] r_len_r, n_len_r;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_space, n_space;
    logic          r_redraw, n_redraw;
    logic          r_dir, n_dir;
    logic          r_have;
    logic [2:0]    r_hkind, n_hkind;
    logic [6:0]    r_hchar, n_hchar;

    logic          r_ov;
    logic [2:0]    r_okind;
    logic [7:0]    r_ochar;
    logic          r_olast;

    logic          tok_valid, tok_last, fire, slot_free;
    logic [2:0]    tok_kind;
    logic [7:0]    tok_char;
    logic          wl_en, wr_en;
    logic [AW-1:0] wl_addr, wr_addr, rl_addr, rr_addr;
    logic [6:0]    wl_data, wr_data;
    logic          data_next, do_read;
    logic [LW:0]   len_sum;
    logic [LW-1:0] tmp_len;
    tle_pkg::t_cmd cmd;

    // First state of a redraw of the text right of the cursor.
    function automatic logic [3:0] f_redraw(input logic [LW-1:0] len, input logic sp);
        logic [3:0] st;
        if (len != '0) begin
            st = S_ECHO;
        end else if (sp) begin
            st = S_SPACE;
        end else begin
            st = S_IDLE;
        end
        return st;
    endfunction

    assign slot_free  = !r_ov || !i_stall;
    assign fire       = tok_valid && slot_free;
    assign o_valid    = r_ov;
    assign o_kind     = r_okind;
    assign o_out_char = r_ochar;
    assign o_last     = r_olast;
    assign cmd        = i_q_cmd;
    assign len_sum    = {1'b0, r_len_l} + {1'b0, r_len_r};

    // Token offered by the current state.
    always_comb begin
        tok_valid = 1'b0;
        tok_kind  = tle_pkg::KIND_ECHO;
        tok_char  = 8'd0;
        tok_last  = 1'b0;
        unique case (r_state)
            S_HEAD: begin
                tok_valid = 1'b1;
                tok_kind  = r_hkind;
                tok_char  = (r_hkind == tle_pkg::KIND_ECHO) ? {1'b0, r_hchar} : 8'd0;
                tok_last  = !r_redraw || (r_len_r == '0 && !r_space);
            end
            S_ECHO: begin
                tok_valid = r_have;
                tok_char  = {1'b0, r_rq};
            end
            S_SPACE, S_KSP: begin
                tok_valid = 1'b1;
                tok_char  = {1'b0, tle_pkg::CH_SPACE};
            end
            S_BACK, S_KLF: begin
                tok_valid = 1'b1;
                tok_kind  = tle_pkg::KIND_LEFT;
                tok_last  = (r_cnt == ONE);
            end
            S_MOVE: begin
                tok_valid = r_have;
                tok_kind  = r_dir ? tle_pkg::KIND_RIGHT : tle_pkg::KIND_LEFT;
                tok_last  = (r_cnt == ONE);
            end
            S_VALL: begin
                tok_valid = r_have;
                tok_kind  = tle_pkg::KIND_VALUE;
                tok_char  = {1'b0, r_lq};
            end
            S_VALR: begin
                tok_valid = r_have;
                tok_kind  = tle_pkg::KIND_VALUE;
                tok_char  = {1'b0, r_rq};
            end
            S_DONE: begin
                tok_valid = 1'b1;
                tok_kind  = tle_pkg::KIND_DONE;
                tok_last  = 1'b1;
            end
            default: begin
                tok_valid = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state  = r_state;
        n_len_l  = r_len_l;
        n_len_r  = r_len_r;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_space  = r_space;
        n_redraw = r_redraw;
        n_dir    = r_dir;
        n_hkind  = r_hkind;
        n_hchar  = r_hchar;
        o_q_pop  = 1'b0;
        wl_en    = 1'b0;
        wl_addr  = r_len_l[AW-1:0];
        wl_data  = cmd.ch;
        wr_en    = 1'b0;
        wr_addr  = r_len_r[AW-1:0];
        wr_data  = r_lq;
        tmp_len  = r_len_r - ONE;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop = 1'b1;
                    unique case (cmd.op)
                        tle_pkg::ACT_INSERT: begin
                            n_redraw = 1'b1;
                            n_space  = 1'b0;
                            if (!cmd.ch_ok) begin
                                // Dropped character: only the redraw goes out.
                                n_state = f_redraw(r_len_r, 1'b0);
                                n_idx   = r_len_r;
                                n_cnt   = r_len_r;
                            end else if (len_sum >= CAP_SUM) begin
                                n_state = S_HEAD;
                                n_hkind = tle_pkg::KIND_BELL;
                            end else begin
                                wl_en   = 1'b1;
                                n_len_l = r_len_l + ONE;
                                n_state = S_HEAD;
                                n_hkind = tle_pkg::KIND_ECHO;
                                n_hchar = cmd.ch;
                            end
                        end
                        tle_pkg::ACT_BACKSP: begin
                            n_state = S_HEAD;
                            if (r_len_l != '0) begin
                                n_hkind  = tle_pkg::KIND_ERASE;
                                n_redraw = 1'b1;
                                n_space  = 1'b1;
                                n_len_l  = r_len_l - ONE;
                            end else begin
                                n_hkind  = tle_pkg::KIND_BELL;
                                n_redraw = 1'b0;
                            end
                        end
                        tle_pkg::ACT_DELETE: begin
                            if (r_len_r != '0) begin
                                n_len_r = tmp_len;
                                n_space = 1'b1;
                                n_state = f_redraw(tmp_len, 1'b1);
                                n_idx   = tmp_len;
                                n_cnt   = r_len_r;
                            end else begin
                                n_state  = S_HEAD;
                                n_hkind  = tle_pkg::KIND_BELL;
                                n_redraw = 1'b0;
                            end
                        end
                        tle_pkg::ACT_LEFT: begin
                            if (r_len_l != '0) begin
                                n_state = S_MOVE;
                                n_dir   = 1'b0;
                                n_cnt   = ONE;
                            end
                        end
                        tle_pkg::ACT_RIGHT: begin
                            if (r_len_r != '0) begin
                                n_state = S_MOVE;
                                n_dir   = 1'b1;
                                n_cnt   = ONE;
                            end
                        end
                        tle_pkg::ACT_HOME: begin
                            if (r_len_l != '0) begin
                                n_state = S_MOVE;
                                n_dir   = 1'b0;
                                n_cnt   = r_len_l;
                            end
                        end
                        tle_pkg::ACT_END: begin
                            if (r_len_r != '0) begin
                                n_state = S_MOVE;
                                n_dir   = 1'b1;
                                n_cnt   = r_len_r;
                            end
                        end
                        tle_pkg::ACT_KILL: begin
                            if (r_len_r != '0) begin
                                n_state = S_KSP;
                                n_cnt   = r_len_r;
                                n_idx   = r_len_r;
                            end
                        end
                        tle_pkg::ACT_ACCEPT: begin
                            if (r_len_l != '0) begin
                                n_state = S_VALL;
                                n_idx   = '0;
                            end else if (r_len_r != '0) begin
                                n_state = S_VALR;
                                n_idx   = r_len_r;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        tle_pkg::ACT_CANCEL: begin
                            n_state  = S_HEAD;
                            n_hkind  = tle_pkg::KIND_CANCEL;
                            n_redraw = 1'b0;
                            n_len_l  = '0;
                            n_len_r  = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                if (fire) begin
                    if (r_redraw) begin
                        n_state = f_redraw(r_len_r, r_space);
                        n_idx   = r_len_r;
                        n_cnt   = r_len_r + {{(LW-1){1'b0}}, r_space};
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ECHO: begin
                if (fire) begin
                    n_idx = r_idx - ONE;
                    if (r_idx == ONE) begin
                        n_state = r_space ? S_SPACE : S_BACK;
                    end
                end
            end
            S_SPACE: begin
                if (fire) begin
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                if (fire) begin
                    n_cnt = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MOVE: begin
                if (fire) begin
                    // One character crosses the gap with each cursor token.
                    if (r_dir) begin
                        wl_en   = 1'b1;
                        wl_data = r_rq;
                        n_len_r = r_len_r - ONE;
                        n_len_l = r_len_l + ONE;
                    end else begin
                        wr_en   = 1'b1;
                        n_len_l = r_len_l - ONE;
                        n_len_r = r_len_r + ONE;
                    end
                    n_cnt = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_KSP: begin
                if (fire) begin
                    n_cnt = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        n_state = S_KLF;
                        n_cnt   = r_idx;
                    end
                end
            end
            S_KLF: begin
                if (fire) begin
                    n_cnt = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        n_state = S_IDLE;
                        n_len_r = '0;
                    end
                end
            end
            S_VALL: begin
                if (fire) begin
                    n_idx = r_idx + ONE;
                    if (r_idx + ONE == r_len_l) begin
                        if (r_len_r != '0) begin
                            n_state = S_VALR;
                            n_idx   = r_len_r;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_VALR: begin
                if (fire) begin
                    n_idx = r_idx - ONE;
                    if (r_idx == ONE) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (fire) begin
                    n_state = S_IDLE;
                    n_len_l = '0;
                    n_len_r = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The read register of each store is refilled only when its word is used or holds none yet,
    // so a stalled output keeps the fetched character in place.
    always_comb begin
        data_next = (n_state == S_ECHO) || (n_state == S_MOVE) ||
                    (n_state == S_VALL) || (n_state == S_VALR);
        do_read   = data_next && (fire || !r_have);
        rl_addr   = (n_state == S_MOVE) ? AW'(n_len_l - ONE) : n_idx[AW-1:0];
        rr_addr   = (n_state == S_MOVE) ? AW'(n_len_r - ONE) : AW'(n_idx - ONE);
    end

    always_ff @(posedge i_clk) begin
        if (wl_en) begin
            mem_l[wl_addr] <= wl_data;
        end
        if (wr_en) begin
            mem_r[wr_addr] <= wr_data;
        end
        if (do_read) begin
            r_lq <= mem_l[rl_addr];
            r_rq <= mem_r[rr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len_l <= '0;
            r_len_r <= '0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len_l <= n_len_l;
            r_len_r <= n_len_r;
            r_have  <= data_next;
            if (fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_space  <= n_space;
        r_redraw <= n_redraw;
        r_dir    <= n_dir;
        r_hkind  <= n_hkind;
        r_hchar  <= n_hchar;
        if (fire) begin
            r_okind <= tok_kind;
            r_ochar <= tok_char;
            r_olast <= tok_last;
        end
    end

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_sum <= CAP_SUM)
        else $error("line length beyond capacity");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && tok_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final token");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BACK || r_state == S_MOVE || r_state == S_KSP ||
         r_state == S_KLF) |-> (r_cnt != '0))
        else $error("token count ran out inside a counted phase");

    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ECHO || r_state == S_VALR) |-> (r_idx != '0))
        else $error("read index ran out inside a read phase");

endmodule

/* hdl/terminal_line_editor_core.sv */
// Top level of the terminal line editor: front, command queue and back.
//
//  channel  | handshake          | word
//  ---------+--------------------+-----------------------------------
//  in       | i_valid / o_stall  | i_action, i_char_code
//  out      | o_valid / i_stall  | o_kind, o_out_char, o_last
//
// A key event moves from the input register into the queue, and the back
// dispatches it from the queue head when it is idle. Text store reads are
// issued at the edge that enters a phase, so phases follow each other without
// a gap. The back dispatches an item in its idle state and then offers the
// item's tokens in order; a stalled output holds the current token. The
// longest items at the default buffer size have 61 tokens, such as a bell and
// a 60-token redraw. Reset clears the line lengths, the queue and all valid
// flags; the text stores need no clearing. An output stall holds the back and,
// once the queue is full, the input side as well.
module terminal_line_editor_core #(
    parameter int BUFFER_SIZE = tle_pkg::BUFFER_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_action,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    tle_pkg::t_cmd    w_push_cmd;
    tle_pkg::t_cmd    w_head_cmd;
    tle_pkg::t_q_stat w_q_stat;
    logic             w_push;
    logic             w_pop;

    tle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    tle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_q_stat)
    );

    tle_back #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_cmd    (w_head_cmd),
        .i_q_stat   (w_q_stat),
        .o_q_pop    (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule
